// ===== hw/rtl/bucketed_hash_table_assert.svh =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_assert
// Assertion macros shared by the bucketed hash table modules.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_ASSERT_SVH

// property must hold at every rising clock edge out of reset
`define BHT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bucketed_hash_table: assertion failed");

// condition must never be seen out of reset
`define BHT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("bucketed_hash_table: forbidden condition seen");

`endif

// ===== hw/rtl/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// Types and constants of the bucketed hash table.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 6;

	// command codes; the unused code is served by default arms
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2
	} command_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_REPLACED  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_REMOVED   = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_FOUND     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUCKET,
		S_READ,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] value_out;
		logic               table_empty;
		logic [COUNT_W-1:0] entry_count;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic bucket_en;
		logic read_en;
		logic exec_en;
	} ctrl_cmd_t;

endpackage

// ===== hw/rtl/bht_ctrl.sv =====
// ----------------------------------------------------------------------------
// bht_ctrl
// Sequencer: accept, bucket select, bucket read, execute and write back.
// ----------------------------------------------------------------------------
`include "bucketed_hash_table_assert.svh"

module bht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output bht_pkg::ctrl_cmd_t cmd
);
	import bht_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_BUCKET;
				end
			end
			S_BUCKET: begin
				cmd.bucket_en = 1'b1;
				state_d       = S_READ;
			end
			S_READ: begin
				cmd.read_en = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec_en = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`BHT_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0(cmd))
	`BHT_ASSERT(a_exec_after_read, clk, arst_n, cmd.exec_en |-> $past(cmd.read_en))
	`BHT_ASSERT(a_read_after_bucket, clk, arst_n, cmd.read_en |-> $past(cmd.bucket_en))

endmodule

// ===== hw/rtl/bht_bucket_mod.sv =====
// ----------------------------------------------------------------------------
// bht_bucket_mod
// Bucket index as key modulo the bucket count, by reciprocal multiply.
// ----------------------------------------------------------------------------
`include "bucketed_hash_table_assert.svh"

module bht_bucket_mod #(
	parameter int unsigned NUM_BUCKETS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           calc,
	input  logic [bht_pkg::KEY_W-1:0]      key,
	output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);
	import bht_pkg::*;

	localparam int unsigned BUCKET_W = $clog2(NUM_BUCKETS);
	// extra fraction bits keep the quotient exact for buckets up to 64
	localparam int unsigned SHIFT    = KEY_W + 6;
	localparam int unsigned PROD_W   = KEY_W + SHIFT;
	localparam logic [SHIFT-1:0] RECIP =
		SHIFT'((64'd1 << SHIFT) / NUM_BUCKETS + 64'd1);
	localparam logic [KEY_W-1:0] NB_K = KEY_W'(NUM_BUCKETS);

	logic [KEY_W-1:0]    key_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [KEY_W-1:0]    quot;
	logic [KEY_W-1:0]    diff;
	logic [KEY_W-1:0]    rem;
	logic [BUCKET_W-1:0] bucket_q;

	always_ff @(posedge clk) begin
		if (load) begin
			key_s1  <= key;
			prod_s1 <= PROD_W'(key) * PROD_W'(RECIP);
		end
	end

	always_comb begin
		quot = KEY_W'(prod_s1 >> SHIFT);
		diff = key_s1 - KEY_W'(quot * NB_K);
		rem  = (diff >= NB_K) ? (diff - NB_K) : diff;
	end

	always_ff @(posedge clk) begin
		if (calc) begin
			bucket_q <= BUCKET_W'(rem);
		end
	end

	assign bucket = bucket_q;

	`BHT_ASSERT(a_bucket_range, clk, arst_n, $past(calc) |-> (bucket_q < BUCKET_W'(NUM_BUCKETS - 1) || bucket_q == BUCKET_W'(NUM_BUCKETS - 1)))

endmodule

// ===== hw/rtl/bht_dp.sv =====
// ----------------------------------------------------------------------------
// bht_dp
// Bucket store, slot compare, write back and entry count.
// ----------------------------------------------------------------------------
`include "bucketed_hash_table_assert.svh"

module bht_dp #(
	parameter int unsigned NUM_BUCKETS      = 10,
	parameter int unsigned SLOTS_PER_BUCKET = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bht_pkg::ctrl_cmd_t             cmd,
	input  bht_pkg::request_t              request,
	input  logic [$clog2(NUM_BUCKETS)-1:0] bucket,
	output logic                           done,
	output bht_pkg::result_t               result
);
	import bht_pkg::*;

	localparam int unsigned TOTAL    = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int unsigned CNT_W    = $clog2(TOTAL + 1);
	localparam int unsigned SLOT_W   = KEY_W + VALUE_W;
	localparam int unsigned ROW_W    = SLOTS_PER_BUCKET * SLOT_W;
	localparam int unsigned IDX_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

	// one row per bucket holds the keys and values of all its slots
	logic [ROW_W-1:0] mem [NUM_BUCKETS];

	logic [SLOTS_PER_BUCKET-1:0] valid_q [NUM_BUCKETS];
	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	result_t                     result_q;

	logic [CMD_W-1:0]            cmd_q;
	logic [KEY_W-1:0]            key_q;
	logic [VALUE_W-1:0]          value_q;
	logic [ROW_W-1:0]            rd_row_q;
	logic [SLOTS_PER_BUCKET-1:0] rd_valid_q;

	logic [SLOTS_PER_BUCKET-1:0] hit_vec;
	logic                        hit;
	logic                        free_any;
	logic [IDX_W-1:0]            hit_idx;
	logic [IDX_W-1:0]            free_idx;
	logic                        wr_en;
	logic [ROW_W-1:0]            wr_row;
	logic [SLOTS_PER_BUCKET-1:0] new_valid;
	logic [CNT_W-1:0]            cnt_next;
	status_t                     status;
	logic [VALUE_W-1:0]          vout;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= request.command;
			key_q   <= request.key;
			value_q <= request.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_en) begin
			rd_row_q   <= mem[bucket];
			rd_valid_q <= valid_q[bucket];
		end
		if (cmd.exec_en && wr_en) begin
			mem[bucket] <= wr_row;
		end
	end

	// slot compare and lowest free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
			hit_vec[s] = rd_valid_q[s] && (rd_row_q[s*SLOT_W +: KEY_W] == key_q);
		end
		for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
			if (hit_vec[s]) begin
				hit_idx = IDX_W'(s);
			end
			if (!rd_valid_q[s]) begin
				free_idx = IDX_W'(s);
			end
		end
		hit      = |hit_vec;
		free_any = ~&rd_valid_q;
	end

	always_comb begin
		status    = STAT_NOT_FOUND;
		vout      = '0;
		wr_en     = 1'b0;
		wr_row    = rd_row_q;
		new_valid = rd_valid_q;
		cnt_next  = cnt_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (hit) begin
					wr_en  = 1'b1;
					wr_row[hit_idx*SLOT_W + KEY_W +: VALUE_W] = value_q;
					status = STAT_REPLACED;
				end else if (free_any) begin
					wr_en  = 1'b1;
					wr_row[free_idx*SLOT_W +: KEY_W]           = key_q;
					wr_row[free_idx*SLOT_W + KEY_W +: VALUE_W] = value_q;
					new_valid[free_idx] = 1'b1;
					cnt_next = cnt_q + 1'b1;
					status   = STAT_INSERTED;
				end else begin
					status = STAT_FULL;
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					new_valid[hit_idx] = 1'b0;
					if (cnt_q != '0) begin
						cnt_next = cnt_q - 1'b1;
					end
					status = STAT_REMOVED;
				end
			end
			CMD_LOOKUP: begin
				if (hit) begin
					vout   = rd_row_q[hit_idx*SLOT_W + KEY_W +: VALUE_W];
					status = STAT_FOUND;
				end
			end
			default: begin
				status = STAT_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec_en;
			if (cmd.exec_en) begin
				valid_q[bucket] <= new_valid;
				cnt_q           <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_en) begin
			result_q.status      <= status;
			result_q.value_out   <= vout;
			result_q.table_empty <= (cnt_next == '0);
			result_q.entry_count <= COUNT_W'(cnt_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`BHT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(TOTAL))
	`BHT_ASSERT(a_insert_counts, clk, arst_n, (done_q && result_q.status == STAT_INSERTED) |-> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
	`BHT_ASSERT(a_remove_counts, clk, arst_n, (done_q && result_q.status == STAT_REMOVED) |-> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
	`BHT_NEVER(a_empty_flag, clk, arst_n, done_q && (result_q.table_empty != (cnt_q == '0)))

endmodule

// ===== hw/rtl/bucketed_hash_table.sv =====
// Bucketed key-value table, key hashed to a bucket by key modulo NUM_BUCKETS.
// Request channel: request (command, key, value) is taken at a rising edge with
// start high and busy low. Commands: insert or replace, remove, lookup.
// Result channel: done is high for exactly one cycle with result (status,
// value_out, table_empty, entry_count) valid; the receiver cannot stall, so a
// result must be taken in that cycle.
// Each transaction takes 4 cycles: a reciprocal multiply at accept, the
// modulo correction, the bucket row read, then compare and write back. busy
// is high for the last three; done rises the cycle after the write back, and
// a new request may be taken in that same cycle, so one transaction every
// 4 cycles. The rate is set by the controller, which runs one transaction at
// a time through its four steps with no overlap.
// Reset clears all slot valid bits and the entry count at once, with no
// clearing pass; keys and values of slots never written are never used.
// ----------------------------------------------------------------------------
// bucketed_hash_table
// Top level: controller, bucket modulo unit and table datapath.
// ----------------------------------------------------------------------------
module bucketed_hash_table #(
	parameter int unsigned NUM_BUCKETS      = 10,
	parameter int unsigned SLOTS_PER_BUCKET = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bht_pkg::request_t request,
	output logic              done,
	output bht_pkg::result_t  result
);
	import bht_pkg::*;

	localparam int unsigned BUCKET_W = $clog2(NUM_BUCKETS);

	ctrl_cmd_t           cmd;
	logic [BUCKET_W-1:0] bucket;

	bht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	bht_bucket_mod #(
		.NUM_BUCKETS (NUM_BUCKETS)
	) u_bucket_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.load),
		.calc   (cmd.bucket_en),
		.key    (request.key),
		.bucket (bucket)
	);

	bht_dp #(
		.NUM_BUCKETS      (NUM_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.bucket  (bucket),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bucketed hash table. Requests go in through the
// start/busy handshake with random gaps. A local model of the slot table
// predicts each result. Every done pulse is checked field by field against
// the oldest prediction that is still waiting.
// ----------------------------------------------------------------------------
module tb;
	import bht_pkg::*;

	localparam int unsigned NUM_BUCKETS      = 10;
	localparam int unsigned SLOTS_PER_BUCKET = 4;
	localparam int unsigned TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
	localparam int unsigned DRAIN_CYCLES     = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	// model of the slot table
	bit                 tbl_valid [TOTAL_SLOTS];
	logic [KEY_W-1:0]   tbl_key   [TOTAL_SLOTS];
	logic [VALUE_W-1:0] tbl_value [TOTAL_SLOTS];
	int                 live_count = 0;

	result_t pending_results [$];
	int      mismatch_count = 0;
	bit      idle_off = 1'b0;

	bucketed_hash_table #(
		.NUM_BUCKETS      (NUM_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("Regression FAIL");
		$finish;
	end

	// applies one request to the model table and returns what it reports
	function automatic result_t apply_table_op(request_t req);
		int      base;
		int      hit;
		int      slot;
		bit      placed;
		result_t res;
		base = (req.key % NUM_BUCKETS) * SLOTS_PER_BUCKET;
		hit = -1;
		placed = 1'b0;
		res.status = STAT_NOT_FOUND;
		res.value_out = '0;
		for (slot = 0; slot < SLOTS_PER_BUCKET; slot++) begin
			if (hit < 0 && tbl_valid[base+slot] && tbl_key[base+slot] == req.key)
				hit = base + slot;
		end
		case (req.command)
			CMD_INSERT: begin
				if (hit >= 0) begin
					tbl_value[hit] = req.value;
					res.status = STAT_REPLACED;
				end else begin
					res.status = STAT_FULL;
					// lowest numbered free slot wins
					for (slot = 0; slot < SLOTS_PER_BUCKET; slot++) begin
						if (!placed && !tbl_valid[base+slot]) begin
							tbl_valid[base+slot] = 1'b1;
							tbl_key[base+slot] = req.key;
							tbl_value[base+slot] = req.value;
							live_count++;
							placed = 1'b1;
							res.status = STAT_INSERTED;
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					tbl_valid[hit] = 1'b0;
					if (live_count > 0)
						live_count--;
					res.status = STAT_REMOVED;
				end
			end
			CMD_LOOKUP: begin
				if (hit >= 0) begin
					res.value_out = tbl_value[hit];
					res.status = STAT_FOUND;
				end
			end
			default: ;
		endcase
		res.table_empty = (live_count == 0);
		res.entry_count = COUNT_W'(live_count);
		return res;
	endfunction

	function automatic int pick_gap();
		if (idle_off || $urandom_range(0, 99) >= 26)
			return 0;
		return $urandom_range(1, 5);
	endfunction

	// crowded keys fill buckets, far keys cover the upper key bits
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return KEY_W'($urandom_range(0, 79));
		if (r < 85)
			return KEY_W'(10 * $urandom_range(0, 6552) + $urandom_range(0, 9));
		return KEY_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [CMD_W-1:0] pick_command(int w_ins, int w_rem, int w_look);
		int r;
		r = $urandom_range(0, 99);
		if (r < w_ins)
			return CMD_INSERT;
		if (r < w_ins + w_rem)
			return CMD_REMOVE;
		if (r < w_ins + w_rem + w_look)
			return CMD_LOOKUP;
		return CMD_UNUSED;
	endfunction

	// one transaction: optional gap, then hold start until busy is low at an edge
	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		int       gap;
		request_t req;
		req.command = cmd;
		req.key = k;
		req.value = v;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_table_op(req));
	endtask

	task automatic send_random(input int count, input int w_ins, input int w_rem,
			input int w_look);
		repeat (count)
			send_request(pick_command(w_ins, w_rem, w_look), pick_key(), $urandom());
	endtask

	task automatic test_directed();
		send_request(CMD_INSERT, 16'd0, 32'h0000_0000);
		send_request(CMD_INSERT, 16'hffff, 32'hffff_ffff);
		send_request(CMD_LOOKUP, 16'd0, 32'hffff_ffff);
		send_request(CMD_LOOKUP, 16'hffff, 32'h0000_0000);
		send_request(CMD_INSERT, 16'd0, 32'h5a5a_a5a5);
		send_request(CMD_LOOKUP, 16'd0, 32'h0);
		send_request(CMD_REMOVE, 16'd1234, 32'h0);
		send_request(CMD_LOOKUP, 16'd7, 32'h0);
		// unused command code must leave the table alone
		send_request(CMD_UNUSED, 16'd0, 32'hffff_ffff);
		// 65535 already sits in bucket five, fill the rest of it
		send_request(CMD_INSERT, 16'd15, 32'h1111_0015);
		send_request(CMD_INSERT, 16'd25, 32'h1111_0025);
		send_request(CMD_INSERT, 16'd35, 32'h1111_0035);
		send_request(CMD_INSERT, 16'd45, 32'h1111_0045);
		send_request(CMD_REMOVE, 16'd25, 32'h0);
		send_request(CMD_INSERT, 16'd45, 32'h2222_0045);
		send_request(CMD_LOOKUP, 16'd45, 32'h0);
		send_request(CMD_REMOVE, 16'd0, 32'h0);
		send_request(CMD_REMOVE, 16'hffff, 32'h0);
		send_request(CMD_REMOVE, 16'd15, 32'h0);
		send_request(CMD_REMOVE, 16'd35, 32'h0);
		send_request(CMD_REMOVE, 16'd45, 32'h0);
		send_request(CMD_REMOVE, 16'd0, 32'h0);
	endtask

	task automatic test_table_fill();
		send_random(300, 70, 15, 10);
	endtask

	task automatic test_table_drain();
		send_random(300, 15, 65, 15);
	endtask

	task automatic test_random_mix();
		send_random(400, 35, 30, 30);
		idle_off = 1'b1;
		send_random(300, 35, 30, 30);
		idle_off = 1'b0;
		send_random(350, 35, 30, 30);
	endtask

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result at %0t: status %0d value %h empty %b count %0d",
						$realtime, result.status, result.value_out, result.table_empty,
						result.entry_count);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result.status !== exp_res.status || result.value_out !== exp_res.value_out
						|| result.table_empty !== exp_res.table_empty
						|| result.entry_count !== exp_res.entry_count) begin
					if (mismatch_count < 10)
						$display("mismatch at %0t: exp %0d/%h/%b/%0d got %0d/%h/%b/%0d",
							$realtime, exp_res.status, exp_res.value_out,
							exp_res.table_empty, exp_res.entry_count, result.status,
							result.value_out, result.table_empty, result.entry_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < TOTAL_SLOTS; i++)
			tbl_valid[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_fill();
		test_table_drain();
		test_random_mix();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bht_pkg.sv
hw/rtl/bht_ctrl.sv
hw/rtl/bht_bucket_mod.sv
hw/rtl/bht_dp.sv
hw/rtl/bucketed_hash_table.sv
test/tb.sv
